FILE: hdl/etp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// etp_pkg
// Types, codes and tables shared by the 8-bit timer/counter with PWM.
// ----------------------------------------------------------------------------
package etp_pkg;

    localparam int PRESCALE_W = 10;

    // Prescaler tap set: 0 = 1/8/64/256/1024 with external clock on 6/7,
    // 1 = 1/8/32/64/128/256/1024.
    localparam bit PRESCALE_SET = 1'b0;

    // Low-bit masks of the prescaler count, indexed by clock select
    localparam logic [PRESCALE_W-1:0] TAP_MASK_A [8] = '{
        10'h000, 10'h000, 10'h007, 10'h03F, 10'h0FF, 10'h3FF, 10'h000, 10'h000
    };
    localparam logic [PRESCALE_W-1:0] TAP_MASK_B [8] = '{
        10'h000, 10'h000, 10'h007, 10'h01F, 10'h03F, 10'h07F, 10'h0FF, 10'h3FF
    };

    typedef enum logic [1:0] {
        WM_NORMAL = 2'd0,
        WM_PHASE  = 2'd1,
        WM_CTC    = 2'd2,
        WM_FAST   = 2'd3
    } wave_mode_t;

    // Clock select codes
    localparam logic [2:0] CS_STOP     = 3'd0;
    localparam logic [2:0] CS_EXT_FALL = 3'd6;
    localparam logic [2:0] CS_EXT_RISE = 3'd7;

    // Output actions
    localparam logic [1:0] ACT_OFF    = 2'd0;
    localparam logic [1:0] ACT_TOGGLE = 2'd1;
    localparam logic [1:0] ACT_CLEAR  = 2'd2;
    localparam logic [1:0] ACT_SET    = 2'd3;

    // Item modes
    localparam logic [2:0] MODE_TICK        = 3'd0;
    localparam logic [2:0] MODE_WRITE_COUNT = 3'd1;
    localparam logic [2:0] MODE_WRITE_CMP   = 3'd2;
    localparam logic [2:0] MODE_FORCE_CMP   = 3'd3;
    localparam logic [2:0] MODE_CLEAR_FLAGS = 3'd4;

    // Configuration register indexes
    localparam logic [2:0] CFG_WAVEFORM_MODE = 3'd0;
    localparam logic [2:0] CFG_CLOCK_SELECT  = 3'd1;
    localparam logic [2:0] CFG_OUTPUT_ACTION = 3'd2;
    localparam logic [2:0] CFG_OVF_IRQ_EN    = 3'd3;
    localparam logic [2:0] CFG_CMP_IRQ_EN    = 3'd4;

    localparam logic [7:0] COUNT_TOP = 8'hFF;

    typedef struct packed {
        wave_mode_t  waveform_mode;
        logic [2:0]  clock_select;
        logic [1:0]  output_action;
        logic        overflow_irq_enable;
        logic        compare_irq_enable;
    } etp_cfg_t;

    typedef struct packed {
        logic [PRESCALE_W-1:0] prescale_count;
        logic [7:0]            counter;
        logic [7:0]            compare_buffer;
        logic [7:0]            compare_active;
        logic                  counting_down;
        logic                  pin_level;
        logic [1:0]            flags;          // bit0 overflow, bit1 compare
        logic                  last_ext_pin;
    } etp_state_t;

    typedef struct packed {
        logic [7:0] count;
        logic       compare_pin;
        logic       overflow_flag;
        logic       compare_flag;
        logic       irq;
    } etp_result_t;

endpackage
`default_nettype wire

FILE: hdl/etp_step.sv
`default_nettype none
// ----------------------------------------------------------------------------
// etp_step
// Next timer state and result for one item: prescaler, clock source select,
// counter step per waveform mode, compare output and flags.
// ----------------------------------------------------------------------------
module etp_step
    import etp_pkg::*;
(
    input  wire etp_cfg_t    cfg,
    input  wire etp_state_t  state_cur,
    input  wire logic [2:0]  mode,
    input  wire logic        ext_pin,
    input  wire logic [7:0]  data,
    output etp_state_t       state_next,
    output etp_result_t      result
);

    function automatic logic plain_pin(input logic [1:0] act, input logic pin);
        logic p;
        p = pin;
        unique case (act)
            ACT_TOGGLE: p = ~pin;
            ACT_CLEAR:  p = 1'b0;
            ACT_SET:    p = 1'b1;
            default:    p = pin;
        endcase
        return p;
    endfunction

    function automatic logic pwm_pin(input logic [1:0] act, input logic pin,
                                     input logic lvl);
        logic p;
        p = pin;
        unique case (act)
            ACT_CLEAR: p = lvl;
            ACT_SET:   p = ~lvl;
            default:   p = pin;
        endcase
        return p;
    endfunction

    logic is_pwm;
    assign is_pwm = (cfg.waveform_mode == WM_PHASE) || (cfg.waveform_mode == WM_FAST);

    etp_state_t st;
    logic       fire;
    logic       match;
    logic       dir;
    logic [7:0] old;
    logic [7:0] nxt;
    logic [PRESCALE_W-1:0] mask;

    always_comb
    begin
        st    = state_cur;
        fire  = 1'b0;
        match = 1'b0;
        dir   = 1'b0;
        nxt   = 8'd0;
        old   = state_cur.counter;
        mask  = PRESCALE_SET ? TAP_MASK_B[cfg.clock_select] : TAP_MASK_A[cfg.clock_select];

        unique case (mode)
            MODE_TICK:
            begin
                st.prescale_count = state_cur.prescale_count + 1'b1;
                st.last_ext_pin   = ext_pin;
                if (cfg.clock_select == CS_STOP)
                    fire = 1'b0;
                else if (!PRESCALE_SET && cfg.clock_select == CS_EXT_FALL)
                    fire = state_cur.last_ext_pin & ~ext_pin;
                else if (!PRESCALE_SET && cfg.clock_select == CS_EXT_RISE)
                    fire = ~state_cur.last_ext_pin & ext_pin;
                else
                    fire = (st.prescale_count & mask) == '0;

                if (fire)
                begin
                    // in PWM modes the compare buffer is loaded at top before the match check
                    if (is_pwm && old == COUNT_TOP)
                        st.compare_active = state_cur.compare_buffer;
                    match = (old == st.compare_active);

                    unique case (cfg.waveform_mode)
                        WM_NORMAL, WM_CTC:
                        begin
                            st.counter = old + 8'd1;
                            if (match)
                            begin
                                st.flags[1]  = 1'b1;
                                st.pin_level = plain_pin(cfg.output_action,
                                                         state_cur.pin_level);
                                if (cfg.waveform_mode == WM_CTC)
                                    st.counter = 8'd0;
                            end
                            if (old == COUNT_TOP)
                                st.flags[0] = 1'b1;
                        end
                        WM_FAST:
                        begin
                            st.counter = old + 8'd1;
                            if (match)
                            begin
                                st.flags[1]  = 1'b1;
                                st.pin_level = pwm_pin(cfg.output_action,
                                                       state_cur.pin_level, 1'b0);
                            end
                            // wrap drive wins over a match at top
                            if (old == COUNT_TOP)
                            begin
                                st.flags[0]  = 1'b1;
                                st.pin_level = pwm_pin(cfg.output_action,
                                                       st.pin_level, 1'b1);
                            end
                        end
                        WM_PHASE:
                        begin
                            if (!state_cur.counting_down)
                            begin
                                if (old == COUNT_TOP)
                                begin
                                    dir = 1'b1;
                                    nxt = COUNT_TOP - 8'd1;
                                end
                                else
                                begin
                                    dir = 1'b0;
                                    nxt = old + 8'd1;
                                end
                            end
                            else
                            begin
                                if (old == 8'd0)
                                begin
                                    dir = 1'b0;
                                    nxt = 8'd1;
                                end
                                else
                                begin
                                    dir = 1'b1;
                                    nxt = old - 8'd1;
                                end
                            end
                            if (match)
                            begin
                                st.flags[1]  = 1'b1;
                                st.pin_level = pwm_pin(cfg.output_action,
                                                       state_cur.pin_level, dir);
                            end
                            if (old == 8'd0 && state_cur.counting_down)
                                st.flags[0] = 1'b1;
                            st.counting_down = dir;
                            st.counter       = nxt;
                        end
                        default: st.counter = old;
                    endcase
                end
            end
            MODE_WRITE_COUNT:
                st.counter = data;
            MODE_WRITE_CMP:
            begin
                st.compare_buffer = data;
                if (!is_pwm)
                    st.compare_active = data;
            end
            MODE_FORCE_CMP:
            begin
                if (!is_pwm)
                    st.pin_level = plain_pin(cfg.output_action, state_cur.pin_level);
            end
            MODE_CLEAR_FLAGS:
                st.flags = state_cur.flags & ~data[1:0];
            default:
                st = state_cur;
        endcase
    end

    logic connected;
    assign connected = (cfg.output_action != ACT_OFF)
                     && !(is_pwm && cfg.output_action == ACT_TOGGLE);

    assign state_next           = st;
    assign result.count         = st.counter;
    assign result.compare_pin   = connected & st.pin_level;
    assign result.overflow_flag = st.flags[0];
    assign result.compare_flag  = st.flags[1];
    assign result.irq           = (st.flags[0] & cfg.overflow_irq_enable)
                                | (st.flags[1] & cfg.compare_irq_enable);

endmodule
`default_nettype wire

FILE: hdl/eight_bit_timer_pwm.sv
`default_nettype none
// ----------------------------------------------------------------------------
// eight_bit_timer_pwm
// 8-bit timer/counter with prescaler, external clock, compare output and PWM.
// ----------------------------------------------------------------------------
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------------------------
//  in       | in_valid / in_stall  | mode, ext_pin, data
//  out      | out_valid / out_stall| count, compare_pin, overflow_flag,
//           |                      | compare_flag, irq
//  cfg      | cfg_valid / cfg_ready| cfg_index, cfg_data
//
//  One item per cycle unless in_stall is high: the step logic sits between
//  the timer state and a single result register, and the result appears the
//  cycle after acceptance. in_stall is raised only while a result is held and
//  out_stall is high. Reset clears the timer state, configuration and result
//  valid. cfg_ready is always high.
// ----------------------------------------------------------------------------
module eight_bit_timer_pwm
    import etp_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,

    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [2:0] mode,
    input  wire logic       ext_pin,
    input  wire logic [7:0] data,

    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [7:0]      count,
    output logic            compare_pin,
    output logic            overflow_flag,
    output logic            compare_flag,
    output logic            irq,

    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [2:0] cfg_index,
    input  wire logic [7:0] cfg_data
);

    etp_cfg_t    cfg_reg;
    etp_cfg_t    cfg_next;
    etp_state_t  state_reg;
    etp_state_t  state_next;
    etp_result_t result_reg;
    etp_result_t result_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        in_accept;

    assign cfg_ready = 1'b1;
    assign in_stall  = out_valid_reg & out_stall;
    assign in_accept = in_valid & ~in_stall;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_WAVEFORM_MODE: cfg_next.waveform_mode       = wave_mode_t'(cfg_data[1:0]);
                CFG_CLOCK_SELECT:  cfg_next.clock_select        = cfg_data[2:0];
                CFG_OUTPUT_ACTION: cfg_next.output_action       = cfg_data[1:0];
                CFG_OVF_IRQ_EN:    cfg_next.overflow_irq_enable = cfg_data[0];
                CFG_CMP_IRQ_EN:    cfg_next.compare_irq_enable  = cfg_data[0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    etp_step u_step (
        .cfg        (cfg_reg),
        .state_cur  (state_reg),
        .mode       (mode),
        .ext_pin    (ext_pin),
        .data       (data),
        .state_next (state_next),
        .result     (result_next)
    );

    assign out_valid_next = in_accept | (out_valid_reg & out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg       <= '0;
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cfg_reg       <= cfg_next;
            out_valid_reg <= out_valid_next;
            if (in_accept)
                state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
            result_reg <= result_next;
    end

    assign out_valid     = out_valid_reg;
    assign count         = result_reg.count;
    assign compare_pin   = result_reg.compare_pin;
    assign overflow_flag = result_reg.overflow_flag;
    assign compare_flag  = result_reg.compare_flag;
    assign irq           = result_reg.irq;

`ifndef SYNTH
    a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with no result held");

    a_write_count: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && mode == MODE_WRITE_COUNT) |=> (out_valid && count == $past(data)))
        else $error("count write not reflected in result");

    a_clear_ovf: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && mode == MODE_CLEAR_FLAGS && data[0]) |=> !overflow_flag)
        else $error("overflow flag survived clear");
`endif

endmodule
`default_nettype wire

FILE: sim/eight_bit_timer_pwm_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eight_bit_timer_pwm_tb
// Self-checking bench for the 8-bit timer/counter with compare output and PWM.
// A directed table covers reset values, bus operations, unused codes and the
// corner cases of each waveform mode. A random run then walks through sixteen
// register settings and one slow prescaler sweep. Every result is compared with
// a table value or a built-in timer model, under random valid gaps and output stalls.
// ----------------------------------------------------------------------------
module eight_bit_timer_pwm_tb;
    import etp_pkg::*;

    localparam int CLK_PERIOD      = 10;
    localparam int QUIET_LIMIT     = 1000;
    localparam int PHASES          = 16;
    localparam int ITEMS_PER_PHASE = 20;

    // clock source per random phase, waveform mode is phase % 4
    localparam logic [2:0] CLOCK_PLAN [PHASES] = '{
        3'd1, CS_EXT_RISE, 3'd2, CS_EXT_FALL, 3'd1, 3'd3, CS_EXT_RISE, 3'd1,
        CS_STOP, 3'd2, 3'd1, 3'd1, CS_EXT_FALL, 3'd1, 3'd4, 3'd5
    };

    typedef enum logic { ROW_ITEM, ROW_SETUP } row_kind_t;

    typedef struct {
        row_kind_t   kind;
        logic [2:0]  code;
        logic        ext;
        logic [7:0]  val;
        bit          known;
        etp_result_t want;
        etp_cfg_t    setup;
    } plan_row_t;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [2:0] mode;
    logic       ext_pin;
    logic [7:0] data;
    logic       out_valid;
    logic       out_stall;
    logic [7:0] count;
    logic       compare_pin;
    logic       overflow_flag;
    logic       compare_flag;
    logic       irq;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [2:0] cfg_index;
    logic [7:0] cfg_data;

    // timer model state and register copy
    etp_state_t  st;
    etp_cfg_t    cfg_m;
    etp_result_t status_q [$];

    plan_row_t plan [$];

    int  mismatches   = 0;
    int  items_sent   = 0;
    int  results_seen = 0;
    int  reg_writes   = 0;
    int  timer_steps  = 0;
    int  next_gap     = 0;
    int  stall_left   = 0;
    int  quiet_cycles = 0;
    bit  in_calm      = 1'b0;
    bit  out_calm     = 1'b0;
    bit  sweep        = 1'b0;

    eight_bit_timer_pwm u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .mode          (mode),
        .ext_pin       (ext_pin),
        .data          (data),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .count         (count),
        .compare_pin   (compare_pin),
        .overflow_flag (overflow_flag),
        .compare_flag  (compare_flag),
        .irq           (irq),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // ------------------------------------------------------------------------
    // Timer model
    // ------------------------------------------------------------------------
    function automatic logic match_pin(logic pin);
        case (cfg_m.output_action)
            ACT_TOGGLE: return !pin;
            ACT_CLEAR:  return 1'b0;
            ACT_SET:    return 1'b1;
            default:    return pin;
        endcase
    endfunction

    // level is the non-inverting pin level
    function automatic logic pwm_pin(logic pin, logic level);
        case (cfg_m.output_action)
            ACT_CLEAR: return level;
            ACT_SET:   return !level;
            default:   return pin;
        endcase
    endfunction

    task automatic timer_apply(input logic [2:0] m, input logic e, input logic [7:0] d,
                               output etp_result_t r);
        logic                  fire;
        logic                  pwm;
        logic                  linked;
        logic                  dn_next;
        logic [7:0]            old;
        logic [7:0]            nxt;
        logic [PRESCALE_W-1:0] tap;
        pwm  = (cfg_m.waveform_mode == WM_PHASE) || (cfg_m.waveform_mode == WM_FAST);
        fire = 1'b0;
        case (m)
            MODE_TICK:
            begin
                st.prescale_count = st.prescale_count + 1'b1;
                if (cfg_m.clock_select == CS_STOP)
                    fire = 1'b0;
                else if (!PRESCALE_SET && cfg_m.clock_select == CS_EXT_FALL)
                    fire = st.last_ext_pin && !e;
                else if (!PRESCALE_SET && cfg_m.clock_select == CS_EXT_RISE)
                    fire = !st.last_ext_pin && e;
                else
                begin
                    tap  = PRESCALE_SET ? TAP_MASK_B[cfg_m.clock_select]
                                        : TAP_MASK_A[cfg_m.clock_select];
                    fire = (st.prescale_count & tap) == '0;
                end
                st.last_ext_pin = e;
                if (fire)
                begin
                    timer_steps++;
                    old = st.counter;
                    case (cfg_m.waveform_mode)
                        WM_NORMAL, WM_CTC:
                        begin
                            nxt = old + 1'b1;
                            if (old == st.compare_active)
                            begin
                                st.flags[1]  = 1'b1;
                                st.pin_level = match_pin(st.pin_level);
                                if (cfg_m.waveform_mode == WM_CTC)
                                    nxt = 8'h00;
                            end
                            st.counter = nxt;
                            if (old == COUNT_TOP)
                                st.flags[0] = 1'b1;
                        end
                        WM_FAST:
                        begin
                            if (old == COUNT_TOP)
                                st.compare_active = st.compare_buffer;
                            if (old == st.compare_active)
                            begin
                                st.flags[1]  = 1'b1;
                                st.pin_level = pwm_pin(st.pin_level, 1'b0);
                            end
                            st.counter = old + 1'b1;
                            if (old == COUNT_TOP)
                            begin
                                st.flags[0]  = 1'b1;
                                st.pin_level = pwm_pin(st.pin_level, 1'b1);
                            end
                        end
                        default:
                        begin
                            // phase correct: turn at top and bottom
                            if (st.counting_down)
                            begin
                                dn_next = (old != 8'h00);
                                nxt     = dn_next ? old - 1'b1 : 8'h01;
                            end
                            else
                            begin
                                dn_next = (old == COUNT_TOP);
                                nxt     = dn_next ? COUNT_TOP - 1'b1 : old + 1'b1;
                            end
                            if (old == COUNT_TOP)
                                st.compare_active = st.compare_buffer;
                            if (old == st.compare_active)
                            begin
                                st.flags[1]  = 1'b1;
                                st.pin_level = pwm_pin(st.pin_level, dn_next);
                            end
                            if (old == 8'h00 && st.counting_down)
                                st.flags[0] = 1'b1;
                            st.counting_down = dn_next;
                            st.counter       = nxt;
                        end
                    endcase
                end
            end
            MODE_WRITE_COUNT:
                st.counter = d;
            MODE_WRITE_CMP:
            begin
                st.compare_buffer = d;
                if (!pwm)
                    st.compare_active = d;
            end
            MODE_FORCE_CMP:
                if (!pwm)
                    st.pin_level = match_pin(st.pin_level);
            MODE_CLEAR_FLAGS:
                st.flags = st.flags & ~d[1:0];
            default:
                ;
        endcase
        linked = (cfg_m.output_action != ACT_OFF) && !(pwm && cfg_m.output_action == ACT_TOGGLE);
        r.count         = st.counter;
        r.compare_pin   = linked & st.pin_level;
        r.overflow_flag = st.flags[0];
        r.compare_flag  = st.flags[1];
        r.irq           = (st.flags[0] & cfg_m.overflow_irq_enable) |
                          (st.flags[1] & cfg_m.compare_irq_enable);
    endtask

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------
    task automatic send_item(input logic [2:0] m, input logic e, input logic [7:0] d,
                             input bit known, input etp_result_t want);
        etp_result_t r;
        repeat (next_gap) @(posedge clk);
        in_valid <= 1'b1;
        mode     <= m;
        ext_pin  <= e;
        data     <= d;
        do @(posedge clk); while (in_stall);
        timer_apply(m, e, d, r);
        status_q.push_back(known ? want : r);
        items_sent++;
        if ($urandom_range(0, 39) == 0)
            in_calm = !in_calm;
        next_gap = (in_calm || sweep) ? 0 : $urandom_range(0, 19);
        if (next_gap != 0)
            in_valid <= 1'b0;
    endtask

    // drop valid and let the block drain before touching registers
    task automatic settle();
        if (next_gap == 0)
            in_valid <= 1'b0;
        while (status_q.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic load_config(input etp_cfg_t c);
        logic [2:0] idx;
        logic [7:0] wr;
        for (idx = CFG_WAVEFORM_MODE; idx <= CFG_CMP_IRQ_EN; idx++)
        begin
            wr = 8'($urandom);
            case (idx)
                CFG_WAVEFORM_MODE: wr[1:0] = c.waveform_mode;
                CFG_CLOCK_SELECT:  wr[2:0] = c.clock_select;
                CFG_OUTPUT_ACTION: wr[1:0] = c.output_action;
                CFG_OVF_IRQ_EN:    wr[0]   = c.overflow_irq_enable;
                default:           wr[0]   = c.compare_irq_enable;
            endcase
            cfg_valid <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= wr;
            do @(posedge clk); while (!cfg_ready);
            reg_writes++;
        end
        cfg_valid <= 1'b0;
        cfg_m = c;
    endtask

    task automatic random_item();
        logic [2:0] m;
        logic [7:0] d;
        int         pick;
        pick = $urandom_range(0, 99);
        d    = 8'($urandom);
        if (pick < 62)
            m = MODE_TICK;
        else if (pick < 72)
        begin
            m = MODE_WRITE_COUNT;
            // aim near top, bottom and the compare value so wraps and matches happen
            case ($urandom_range(0, 3))
                0: d = COUNT_TOP - 8'($urandom_range(0, 3));
                1: d = st.compare_active - 8'($urandom_range(0, 2));
                2: d = 8'($urandom_range(0, 3));
                default: ;
            endcase
        end
        else if (pick < 80)
            m = MODE_WRITE_CMP;
        else if (pick < 86)
            m = MODE_FORCE_CMP;
        else if (pick < 94)
            m = MODE_CLEAR_FLAGS;
        else
            m = 3'($urandom_range(5, 7));
        send_item(m, 1'($urandom_range(0, 1)), d, 1'b0, '0);
    endtask

    // ------------------------------------------------------------------------
    // Directed table rows
    // ------------------------------------------------------------------------
    function automatic plan_row_t item_row(logic [2:0] m, logic e, logic [7:0] d);
        plan_row_t row;
        row.kind  = ROW_ITEM;
        row.code  = m;
        row.ext   = e;
        row.val   = d;
        row.known = 1'b0;
        row.want  = '0;
        row.setup = '0;
        return row;
    endfunction

    function automatic plan_row_t known_row(logic [2:0] m, logic e, logic [7:0] d,
                                            logic [7:0] cnt, logic pin, logic ovf,
                                            logic cmp, logic intr);
        plan_row_t row;
        row       = item_row(m, e, d);
        row.known = 1'b1;
        row.want  = {cnt, pin, ovf, cmp, intr};
        return row;
    endfunction

    function automatic plan_row_t setup_row(wave_mode_t wm, logic [2:0] cs, logic [1:0] act,
                                            logic oie, logic cie);
        plan_row_t row;
        row                           = item_row(MODE_TICK, 1'b0, 8'h00);
        row.kind                      = ROW_SETUP;
        row.setup.waveform_mode       = wm;
        row.setup.clock_select        = cs;
        row.setup.output_action       = act;
        row.setup.overflow_irq_enable = oie;
        row.setup.compare_irq_enable  = cie;
        return row;
    endfunction

    // ------------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------------
    function automatic void field_check(string field, logic [7:0] want, logic [7:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %0h got %0h", $time, field, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk)
    begin
        if (out_valid && !out_stall)
        begin
            results_seen++;
            if (status_q.size() == 0)
            begin
                $display("%0t: unexpected result, count %0h", $time, count);
                mismatches++;
            end
            else
            begin
                etp_result_t w;
                w = status_q.pop_front();
                field_check("count", w.count, count);
                field_check("compare_pin", 8'(w.compare_pin), 8'(compare_pin));
                field_check("overflow_flag", 8'(w.overflow_flag), 8'(overflow_flag));
                field_check("compare_flag", 8'(w.compare_flag), 8'(compare_flag));
                field_check("irq", 8'(w.irq), 8'(irq));
            end
            if ($urandom_range(0, 39) == 0)
                out_calm = !out_calm;
            stall_left = out_calm ? 0 : $urandom_range(0, 19);
            out_stall <= (stall_left != 0);
        end
        else if (out_stall)
        begin
            stall_left--;
            if (stall_left == 0)
                out_stall <= 1'b0;
        end
    end

    initial
    begin : watchdog
        while (quiet_cycles < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("%0t: nothing moved for %0d cycles", $time, QUIET_LIMIT);
        $display("Mismatches found");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        etp_cfg_t c;
        int       mark;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        mode      = MODE_TICK;
        ext_pin   = 1'b0;
        data      = 8'h00;
        out_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_WAVEFORM_MODE;
        cfg_data  = 8'h00;
        st        = '0;
        cfg_m     = '0;

        plan = '{
            // reset state: clock stopped, pin disconnected
            known_row(MODE_TICK,        1'b1, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0),
            known_row(MODE_WRITE_COUNT, 1'b0, 8'hFF, 8'hFF, 1'b0, 1'b0, 1'b0, 1'b0),
            known_row(3'd5,             1'b1, 8'hAA, 8'hFF, 1'b0, 1'b0, 1'b0, 1'b0),
            known_row(MODE_FORCE_CMP,   1'b0, 8'h55, 8'hFF, 1'b0, 1'b0, 1'b0, 1'b0),
            known_row(MODE_CLEAR_FLAGS, 1'b1, 8'hFF, 8'hFF, 1'b0, 1'b0, 1'b0, 1'b0),
            // normal mode, match at top toggles the pin and wraps
            setup_row(WM_NORMAL, 3'd1, ACT_TOGGLE, 1'b1, 1'b1),
            item_row(MODE_WRITE_CMP, 1'b0, 8'hFF),
            known_row(MODE_TICK,        1'b0, 8'h00, 8'h00, 1'b1, 1'b1, 1'b1, 1'b1),
            item_row(MODE_FORCE_CMP,   1'b1, 8'h00),
            item_row(MODE_CLEAR_FLAGS, 1'b0, 8'h01),
            // CTC reload on match
            setup_row(WM_CTC, 3'd1, ACT_CLEAR, 1'b1, 1'b0),
            item_row(MODE_WRITE_CMP, 1'b1, 8'h02),
            item_row(MODE_TICK,      1'b0, 8'h00),
            item_row(MODE_TICK,      1'b1, 8'hFF),
            item_row(MODE_TICK,      1'b0, 8'h00),
            // fast PWM inverting, buffered compare loaded at top
            setup_row(WM_FAST, 3'd1, ACT_SET, 1'b0, 1'b1),
            item_row(MODE_WRITE_COUNT, 1'b0, 8'hFE),
            item_row(MODE_WRITE_CMP,   1'b1, 8'h80),
            item_row(MODE_TICK,        1'b0, 8'h00),
            item_row(MODE_TICK,        1'b1, 8'h00),
            // phase correct: turn at top, overflow at bottom
            setup_row(WM_PHASE, 3'd1, ACT_CLEAR, 1'b1, 1'b1),
            item_row(MODE_WRITE_COUNT, 1'b0, 8'hFF),
            item_row(MODE_TICK,        1'b1, 8'h00),
            item_row(MODE_WRITE_COUNT, 1'b0, 8'h00),
            item_row(MODE_TICK,        1'b0, 8'h00),
            // toggle action is reserved in PWM modes; external rising edge
            setup_row(WM_PHASE, CS_EXT_RISE, ACT_TOGGLE, 1'b0, 1'b0),
            item_row(MODE_TICK,      1'b0, 8'h00),
            item_row(MODE_TICK,      1'b1, 8'h00),
            item_row(MODE_FORCE_CMP, 1'b0, 8'h00),
            // external falling edge
            setup_row(WM_NORMAL, CS_EXT_FALL, ACT_SET, 1'b1, 1'b0),
            item_row(MODE_TICK,      1'b0, 8'h00)
        };

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_SETUP)
            begin
                settle();
                load_config(plan[i].setup);
            end
            else
                send_item(plan[i].code, plan[i].ext, plan[i].val, plan[i].known, plan[i].want);
        end

        for (int p = 0; p < PHASES; p++)
        begin
            c.waveform_mode       = wave_mode_t'(p % 4);
            c.clock_select        = CLOCK_PLAN[p];
            c.output_action       = 2'(p / 4);
            c.overflow_irq_enable = 1'($urandom_range(0, 1));
            c.compare_irq_enable  = 1'($urandom_range(0, 1));
            settle();
            load_config(c);
            repeat (ITEMS_PER_PHASE) random_item();
        end

        // slow tap: back-to-back ticks until the divided clock fires
        sweep = 1'b1;
        c.waveform_mode       = WM_FAST;
        c.clock_select        = 3'd4;
        c.output_action       = ACT_CLEAR;
        c.overflow_irq_enable = 1'b1;
        c.compare_irq_enable  = 1'b1;
        settle();
        load_config(c);
        mark = timer_steps;
        while (timer_steps < mark + 1)
            send_item(MODE_TICK, 1'($urandom_range(0, 1)), 8'($urandom), 1'b0, '0);
        sweep = 1'b0;

        settle();
        repeat (4) @(posedge clk);
        $display("Run covered %0d items with %0d counter steps and %0d register writes",
                 items_sent, timer_steps, reg_writes);
        $display("%0d results checked over all waveform modes and clock sources",
                 results_seen);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
